// ===== rtl/core/feal4_variant_block_cipher_defines.svh =====
// Assertion macros for the checker file of the FEAL-4 variant cipher.
// No dependencies; include by bare file name.
`ifndef FEAL4_VARIANT_BLOCK_CIPHER_DEFINES_SVH
`define FEAL4_VARIANT_BLOCK_CIPHER_DEFINES_SVH

// clocked property, attempts dropped while reset is high
`define FEAL4_ASSERT_CLKD(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked property, also checked through reset
`define FEAL4_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/feal4_pkg.sv =====
// Shared types, constants and F-function for the FEAL-4 variant cipher.
// No dependencies.
`default_nettype none

package feal4_pkg;

   localparam int unsigned NumRounds  = 4;
   localparam int unsigned RspLatency = NumRounds + 2;
   localparam int unsigned CsrIdxW    = 3;
   localparam int unsigned KeyW       = 32;

   typedef logic [KeyW-1:0] word_type;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_ROUND_KEY_0   = 3'd0,
      CSR_ROUND_KEY_1   = 3'd1,
      CSR_ROUND_KEY_2   = 3'd2,
      CSR_ROUND_KEY_3   = 3'd3,
      CSR_WHITEN_LEFT   = 3'd4,
      CSR_WHITEN_RIGHT  = 3'd5
   } csr_index_type;

   localparam word_type RoundKey0Rst   = 32'h0001_0203;
   localparam word_type RoundKey1Rst   = 32'h0102_0304;
   localparam word_type RoundKey2Rst   = 32'h0203_0405;
   localparam word_type RoundKey3Rst   = 32'h0304_0506;
   localparam word_type WhitenLeftRst  = 32'h0405_0607;
   localparam word_type WhitenRightRst = 32'h0506_0708;

   function automatic logic [7:0] g_box(input logic [7:0] a, input logic [7:0] b,
                                        input logic m);
      logic [7:0] sum;
      sum = a + b + {7'd0, m};
      return {sum[5:0], sum[7:6]};
   endfunction

   // output byte order reversed against standard FEAL
   function automatic word_type f_box(input word_type x);
      logic [7:0] t0;
      logic [7:0] t1;
      logic [7:0] y0;
      logic [7:0] y2;
      logic [7:0] y3;
      t0 = x[15:8] ^ x[7:0];
      t1 = g_box(x[31:24] ^ x[23:16], t0, 1'b1);
      y0 = g_box(x[31:24], t1, 1'b0);
      y2 = g_box(t0, t1, 1'b0);
      y3 = g_box(x[7:0], y2, 1'b1);
      return {y3, y2, t1, y0};
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/feal4_variant_block_cipher.sv =====
// Top level of the FEAL-4 variant cipher: key registers and round pipeline.
// Depends on feal4_pkg.
//
//   channel   ports                           handshake
//   request   req_action, req_block_in        start high and busy low
//   response  rsp_block_out                   rsp_valid, one cycle, no hold-off
//   csr       csr_index, csr_wdata            csr_write_en
//
// One block enters per clock; the whitening stage loads at the accept edge, one
// register stage per round (four) and the output stage follow, and each result
// is on the ports as soon as the output stage has registered it.
// busy stays low, the pipeline never stalls.
// Synchronous reset clears the key registers to their defaults and all valid bits.
`default_nettype none

module feal4_variant_block_cipher (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_action,
   input  wire logic [63:0]                   req_block_in,
   output logic                               rsp_valid,
   output logic [63:0]                        rsp_block_out,
   input  wire logic                          csr_write_en,
   input  wire logic [feal4_pkg::CsrIdxW-1:0] csr_index,
   input  wire logic [feal4_pkg::KeyW-1:0]    csr_wdata
);
   import feal4_pkg::*;

   word_type round_key_ff [NumRounds];
   word_type whiten_left_ff;
   word_type whiten_right_ff;

   logic     vld_ff [NumRounds+1];
   logic     dec_ff [NumRounds+1];
   word_type l_ff   [NumRounds+1];
   word_type r_ff   [NumRounds+1];

   word_type l_in;
   word_type r_in;
   logic     accept;

   logic        rsp_valid_ff;
   logic [63:0] rsp_block_ff;
   logic [63:0] rsp_block_in;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         round_key_ff[0] <= RoundKey0Rst;
         round_key_ff[1] <= RoundKey1Rst;
         round_key_ff[2] <= RoundKey2Rst;
         round_key_ff[3] <= RoundKey3Rst;
         whiten_left_ff  <= WhitenLeftRst;
         whiten_right_ff <= WhitenRightRst;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_ROUND_KEY_0:  round_key_ff[0] <= csr_wdata;
            CSR_ROUND_KEY_1:  round_key_ff[1] <= csr_wdata;
            CSR_ROUND_KEY_2:  round_key_ff[2] <= csr_wdata;
            CSR_ROUND_KEY_3:  round_key_ff[3] <= csr_wdata;
            CSR_WHITEN_LEFT:  whiten_left_ff  <= csr_wdata;
            CSR_WHITEN_RIGHT: whiten_right_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // decrypt enters the rounds as (R4, L4) of the encrypt schedule
   always_comb begin
      if (req_action) begin
         l_in = req_block_in[63:32];
         r_in = req_block_in[31:0] ^ req_block_in[63:32];
      end else begin
         l_in = req_block_in[63:32] ^ whiten_left_ff;
         r_in = req_block_in[31:0] ^ whiten_right_ff ^ l_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= accept;
      end
      dec_ff[0] <= req_action;
      l_ff[0]   <= l_in;
      r_ff[0]   <= r_in;
   end

   for (genvar i = 0; i < NumRounds; i++) begin : g_round
      word_type key;
      word_type l_nxt;

      assign key   = dec_ff[i] ? round_key_ff[NumRounds-1-i] : round_key_ff[i];
      assign l_nxt = r_ff[i] ^ f_box(l_ff[i] ^ key);

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else begin
            vld_ff[i+1] <= vld_ff[i];
         end
         dec_ff[i+1] <= dec_ff[i];
         l_ff[i+1]   <= l_nxt;
         r_ff[i+1]   <= l_ff[i];
      end
   end

   always_comb begin
      if (dec_ff[NumRounds]) begin
         rsp_block_in = {r_ff[NumRounds] ^ whiten_left_ff,
                         r_ff[NumRounds] ^ l_ff[NumRounds] ^ whiten_right_ff};
      end else begin
         rsp_block_in = {r_ff[NumRounds], r_ff[NumRounds] ^ l_ff[NumRounds]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= vld_ff[NumRounds];
      end
      rsp_block_ff <= rsp_block_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_block_out = rsp_block_ff;

endmodule

`default_nettype wire

// ===== rtl/core/feal4_chk.sv =====
// Port-level checker for the FEAL-4 variant cipher, bound to the top level.
// Depends on feal4_pkg and feal4_variant_block_cipher_defines.svh.
`default_nettype none
`include "feal4_variant_block_cipher_defines.svh"

module feal4_chk (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic rsp_valid
);
   import feal4_pkg::*;

   `FEAL4_ASSERT_CLKD(a_never_busy, clock, reset, !busy, "busy raised")
   `FEAL4_ASSERT_CLKD(a_beat_out, clock, reset, (start && !busy) |-> ##RspLatency rsp_valid, "accepted beat lost")
   `FEAL4_ASSERT_CLKD(a_no_invented, clock, reset, rsp_valid |-> $past(start && !busy, RspLatency), "response without request")
   `FEAL4_ASSERT_ALWAYS(a_reset_flush, clock, reset |=> !rsp_valid, "response after reset")

endmodule

bind feal4_variant_block_cipher feal4_chk u_feal4_chk (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);

`default_nettype wire
